FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on a clock, disabled while reset is low
`define SPT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

FILE: hdl/spt_pkg.sv
// package for the scaled pausable time channels: constants, codes and types
package spt_pkg;

  localparam int unsigned ChannelsDefault = 16;

  localparam int unsigned TickW  = 32;
  localparam int unsigned SpeedW = 10;
  localparam int unsigned TimeW  = 56;
  localparam int unsigned ProdW  = TickW + SpeedW;

  localparam logic [SpeedW-1:0] SpeedNormal = 10'd256;
  localparam logic [SpeedW-1:0] SpeedMax    = 10'd512;

  localparam logic [2:0] OpTick     = 3'd0;
  localparam logic [2:0] OpRead     = 3'd1;
  localparam logic [2:0] OpSetSpeed = 3'd2;
  localparam logic [2:0] OpStopAll  = 3'd3;
  localparam logic [2:0] OpStartAll = 3'd4;
  localparam logic [2:0] OpReset    = 3'd5;

  typedef struct packed {
    logic              running;
    logic [TickW-1:0]  pause;
    logic [TickW-1:0]  offset;
    logic [SpeedW-1:0] speed;
    logic [TimeW-1:0]  acc;
  } chan_rec_t;

  localparam chan_rec_t RecReset = '{
    running: 1'b1,
    pause:   '0,
    offset:  '0,
    speed:   SpeedNormal,
    acc:     '0
  };

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } store_ctl_t;

endpackage

FILE: hdl/scaled_pausable_time_channels.sv
// top level: sequencer for the scaled pausable time channels
//
// Input channel: operation_i, channel_i and new_speed_i, taken when in_valid_i
// and in_ready_o are both high. Output channel: time_value_o and speed_value_o,
// taken when out_valid_o and out_ready_i are both high. Every request gives
// exactly one result, the addressed channel's time and speed after it.
// One request is worked on at a time; in_ready_o is high only when idle.
// Tick, read, set speed and reset channel: the request goes through a memory
// read, the registered multiply and the final add, where the result is
// registered; then the sequencer is idle and takes the next request. Stop all
// and start all first sweep every channel (memory read, then write back),
// then do the same steps for the addressed channel.
// Reset: the tick count clears and every channel reads as running at speed
// 256 with zero time; no clearing pass is needed.
// A result waits in the output register while the receiver stalls; a new
// request is still taken, and its work holds at the final step until the
// output register is free.
module scaled_pausable_time_channels #(
  parameter int unsigned CHANNELS = spt_pkg::ChannelsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 operation_i,
  input  logic [3:0]                 channel_i,
  input  logic signed [10:0]         new_speed_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [spt_pkg::TimeW-1:0]  time_value_o,
  output logic [spt_pkg::SpeedW-1:0] speed_value_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSwRd  = 3'd1;
  localparam logic [2:0] StSwWr  = 3'd2;
  localparam logic [2:0] StChRd  = 3'd3;
  localparam logic [2:0] StChMul = 3'd4;
  localparam logic [2:0] StChAdd = 3'd5;

  logic [2:0] state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [spt_pkg::TickW-1:0] tick_q, tick_d;
  logic [2:0] op_q;
  logic [3:0] ch_q;
  logic [spt_pkg::SpeedW-1:0] req_q;
  logic out_valid_q, out_valid_d;
  logic [spt_pkg::TimeW-1:0] time_q;
  logic [spt_pkg::SpeedW-1:0] speed_q;

  spt_pkg::store_ctl_t ctl;
  logic [IdxW-1:0] addr;
  spt_pkg::chan_rec_t rec, wrec;
  logic [spt_pkg::TickW-1:0] now, elapsed;
  logic [spt_pkg::TimeW-1:0] sum;
  logic [spt_pkg::SpeedW-1:0] clamped;
  logic accept, ch_ok, out_free, mac_load, finish;

  assign accept   = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);
  assign ch_ok    = {28'd0, ch_q} < 32'(CHANNELS);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (new_speed_i < 0) begin
      clamped = '0;
    end else if (new_speed_i > 11'sd512) begin
      clamped = spt_pkg::SpeedMax;
    end else begin
      clamped = new_speed_i[spt_pkg::SpeedW-1:0];
    end
  end

  assign now     = rec.running ? tick_q : rec.pause;
  assign elapsed = now - rec.offset;

  spt_store #(.CHANNELS(CHANNELS)) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .addr_i  (addr),
    .wdata_i (wrec),
    .rdata_o (rec)
  );

  spt_mac u_mac (
    .clk_i     (clk_i),
    .load_i    (mac_load),
    .elapsed_i (elapsed),
    .speed_i   (rec.speed),
    .acc_i     (rec.acc),
    .sum_o     (sum)
  );

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tick_d      = tick_q;
    ctl         = '0;
    addr        = IdxW'(ch_q);
    wrec        = rec;
    mac_load    = 1'b0;
    finish      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      StIdle: begin
        if (accept) begin
          idx_d = '0;
          if (operation_i == spt_pkg::OpTick) begin
            tick_d = tick_q + 32'd1;
          end
          if (operation_i == spt_pkg::OpStopAll || operation_i == spt_pkg::OpStartAll) begin
            state_d = StSwRd;
          end else begin
            state_d = StChRd;
          end
        end
      end
      StSwRd: begin
        ctl.rd_en = 1'b1;
        addr      = idx_q;
        state_d   = StSwWr;
      end
      StSwWr: begin
        addr = idx_q;
        if (op_q == spt_pkg::OpStopAll) begin
          wrec.running = 1'b0;
          if (rec.running) begin
            wrec.pause = tick_q;
          end
        end else begin
          wrec.running = 1'b1;
          if (!rec.running) begin
            wrec.offset = rec.offset + (tick_q - rec.pause);
          end
        end
        ctl.wr_en = 1'b1;
        idx_d     = idx_q + IdxW'(1);
        if (idx_q == IdxW'(CHANNELS - 1)) begin
          state_d = StChRd;
        end else begin
          state_d = StSwRd;
        end
      end
      StChRd: begin
        ctl.rd_en = 1'b1;
        state_d   = StChMul;
      end
      StChMul: begin
        mac_load = 1'b1;
        state_d  = StChAdd;
      end
      StChAdd: begin
        if (out_free) begin
          finish      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (ch_ok && op_q == spt_pkg::OpSetSpeed) begin
            wrec.acc    = sum;
            wrec.offset = now;
            wrec.speed  = req_q;
            ctl.wr_en   = 1'b1;
          end else if (ch_ok && op_q == spt_pkg::OpReset) begin
            ctl.clr = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      idx_q       <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      ch_q  <= channel_i;
      req_q <= clamped;
    end
    if (finish) begin
      if (!ch_ok) begin
        time_q  <= '0;
        speed_q <= '0;
      end else if (op_q == spt_pkg::OpReset) begin
        // cleared channel counts from tick 0 at normal rate
        time_q  <= spt_pkg::TimeW'({tick_q, 8'd0});
        speed_q <= spt_pkg::SpeedNormal;
      end else if (op_q == spt_pkg::OpSetSpeed) begin
        time_q  <= sum;
        speed_q <= req_q;
      end else begin
        time_q  <= sum;
        speed_q <= rec.speed;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign time_value_o  = time_q;
  assign speed_value_o = speed_q;

endmodule

FILE: hdl/spt_store.sv
// per-channel state memory with valid bits that stand in for the reset value
module spt_store #(
  parameter int unsigned CHANNELS = spt_pkg::ChannelsDefault,
  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spt_pkg::store_ctl_t ctl_i,
  input  logic [IdxW-1:0]    addr_i,
  input  spt_pkg::chan_rec_t wdata_i,
  output spt_pkg::chan_rec_t rdata_o
);

  spt_pkg::chan_rec_t mem [CHANNELS];
  spt_pkg::chan_rec_t mem_q;
  logic [CHANNELS-1:0] valid_q;
  logic                rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      mem_q <= mem[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[addr_i] <= 1'b1;
      end else if (ctl_i.clr) begin
        valid_q[addr_i] <= 1'b0;
      end
      if (ctl_i.rd_en) begin
        rd_valid_q <= valid_q[addr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? mem_q : spt_pkg::RecReset;

endmodule

FILE: hdl/spt_mac.sv
// shared multiply-add unit: registered elapsed times speed, then add to accumulator
module spt_mac (
  input  logic                       clk_i,
  input  logic                       load_i,
  input  logic [spt_pkg::TickW-1:0]  elapsed_i,
  input  logic [spt_pkg::SpeedW-1:0] speed_i,
  input  logic [spt_pkg::TimeW-1:0]  acc_i,
  output logic [spt_pkg::TimeW-1:0]  sum_o
);

  logic [spt_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= elapsed_i * speed_i;
    end
  end

  assign sum_o = acc_i + spt_pkg::TimeW'(prod_q);

endmodule

FILE: hdl/spt_checker.sv
// port-level checker for the scaled pausable time channels, bound to the top level
`include "assert_macros.svh"

module spt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [spt_pkg::TimeW-1:0]  time_value_o,
  input logic [spt_pkg::SpeedW-1:0] speed_value_o
);

  `SPT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(time_value_o) && $stable(speed_value_o))
  `SPT_ASSERT(a_busy_after_request, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `SPT_ASSERT(a_speed_range, clk_i, rst_ni, out_valid_o |-> speed_value_o <= spt_pkg::SpeedMax)
  `SPT_ASSERT(a_no_early_result, clk_i, rst_ni, in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)

endmodule

bind scaled_pausable_time_channels spt_checker u_spt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .time_value_o  (time_value_o),
  .speed_value_o (speed_value_o)
);
